### design/oldbp_pkg.sv
// Shared types and constants for the ordered list delete-by-position block.
package oldbp_pkg;

   localparam int Capacity  = 16;
   localparam int DataWidth = 32;
   localparam int CntWidth  = $clog2(Capacity + 1);

   typedef logic signed [DataWidth-1:0] word_type;
   typedef logic [CntWidth-1:0]         cnt_type;

   typedef enum logic [2:0] {
      CMD_APPEND    = 3'd0,
      CMD_DEL_FIRST = 3'd1,
      CMD_DEL_LAST  = 3'd2,
      CMD_DEL_POS   = 3'd3,
      CMD_READ_ALL  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_EMPTY   = 2'd1,
      STS_BAD_POS = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

### design/oldbp_cell.sv
// One list cell: holds a word, loads a new word or takes its neighbor's.
module oldbp_cell (
   input  logic                   clock,
   input  oldbp_pkg::cell_ctl_type ctl,
   input  oldbp_pkg::word_type    new_word,
   input  oldbp_pkg::word_type    next_word,
   output oldbp_pkg::word_type    word_out
);
   import oldbp_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.load) begin
         word_in = new_word;
      end else if (ctl.shift) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

### design/ordered_list_delete_by_position_core.sv
// Top level: bounded ordered list as a chain of cells with stream ports.
//
//   channel  | dir | tdata (low bit up)                         | tlast
//   req      | in  | command[2:0] value[34:3] position[42:35]    | -
//   rsp      | out | status[1:0] value_res[33:2]               | last
//
// Edits (append, deletes) act on the affected cells at once; delete-last
// only lowers the count. Read-all sends the entries from cell 0 as the list
// rotates through it, and the list is back in order after the last entry.
// Reset clears the count and the control state; cell contents are not reset.
// A stalled rsp holds the output register; req is taken only when idle and
// the output register is free or draining.
module ordered_list_delete_by_position_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // command[2:0], value[34:3], position[42:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], value_res[33:2]
   output logic        rsp_tlast
);
   import oldbp_pkg::*;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;
   cnt_type    rd_left_ff, rd_left_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic       rsp_last_ff, rsp_last_in;

   cmd_type     req_cmd;
   logic [31:0] req_value;
   logic [7:0]  req_pos;
   word_type    req_word;
   logic        slot_free;
   logic        req_fire;
   logic        emit_rd;
   logic        do_load;
   logic        do_delete;
   logic        do_rotate;
   logic [7:0]  del_from;
   logic        is_empty;
   logic        is_full;

   cell_ctl_type cell_ctl  [Capacity];
   word_type     cell_word [Capacity];
   word_type     cell_next [Capacity];

   assign req_cmd   = cmd_type'(req_tdata[2:0]);
   assign req_value = req_tdata[34:3];
   assign req_pos   = req_tdata[42:35];
   assign req_word  = word_type'(signed'(req_value));

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign emit_rd    = (state_ff == ST_READ) && slot_free;
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CntWidth'(Capacity));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_cmd == CMD_READ_ALL && !is_empty) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (emit_rd && rd_left_ff == CntWidth'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result control
   always_comb begin
      count_in      = count_ff;
      rd_left_in    = rd_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      do_load       = 1'b0;
      do_delete     = 1'b0;
      do_rotate     = 1'b0;
      del_from      = '0;

      if (req_fire) begin
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         case (req_cmd)
            CMD_APPEND: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = STS_FULL;
               end else begin
                  rsp_status_in = STS_OK;
                  do_load       = 1'b1;
                  count_in      = count_ff + CntWidth'(1);
               end
            end
            CMD_DEL_FIRST: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = STS_EMPTY;
               end else begin
                  rsp_status_in = STS_OK;
                  do_delete     = 1'b1;
                  count_in      = count_ff - CntWidth'(1);
               end
            end
            CMD_DEL_LAST: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = STS_EMPTY;
               end else begin
                  rsp_status_in = STS_OK;
                  count_in      = count_ff - CntWidth'(1);
               end
            end
            CMD_DEL_POS: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = STS_EMPTY;
               end else if (req_pos == 8'd0 || req_pos > 8'(count_ff)) begin
                  rsp_status_in = STS_BAD_POS;
               end else begin
                  rsp_status_in = STS_OK;
                  do_delete     = 1'b1;
                  del_from      = req_pos - 8'd1;
                  count_in      = count_ff - CntWidth'(1);
               end
            end
            CMD_READ_ALL: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STS_EMPTY;
               end else begin
                  rd_left_in = count_ff;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_tready;
            end
         endcase
      end else if (emit_rd) begin
         do_rotate     = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = STS_OK;
         rsp_value_in  = 32'(cell_word[0]);
         rsp_last_in   = (rd_left_ff == CntWidth'(1));
         rd_left_in    = rd_left_ff - CntWidth'(1);
      end
   end

   // cell chain; during read-all the entry at count-1 takes cell 0 (ring)
   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      localparam int Next = (i + 1) % Capacity;

      always_comb begin
         cell_ctl[i].load  = do_load && (count_ff == CntWidth'(i));
         cell_ctl[i].shift = do_rotate || (do_delete && 8'(i) >= del_from);
         if (do_rotate && (count_ff == CntWidth'(i + 1))) begin
            cell_next[i] = cell_word[0];
         end else begin
            cell_next[i] = cell_word[Next];
         end
      end

      oldbp_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .new_word  (req_word),
         .next_word (cell_next[i]),
         .word_out  (cell_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_left_ff   <= rd_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_value_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(Capacity))
      else $error("entry count above capacity");

   a_read_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rd_left_ff != '0) && !is_empty)
      else $error("read-all active with nothing left");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_APPEND && !is_full)
         |=> (count_ff == $past(count_ff) + CntWidth'(1)))
      else $error("append did not grow the list");

   a_read_ends: assert property (@(posedge clock) disable iff (reset)
      (emit_rd && rd_left_ff == CntWidth'(1))
         |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("read-all did not finish with a last result");
`endif

endmodule
